>>> design/polyline_rect_clipper_unit_defines.svh
// Assertion macros for the polyline rectangle clipper.
`ifndef POLYLINE_RECT_CLIPPER_UNIT_DEFINES_SVH
`define POLYLINE_RECT_CLIPPER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset
`define PRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication outside reset
`define PRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PRC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/prc_pkg.sv
// -----------------------------------------------------------------------------
// prc_pkg
// Shared types and codes for the polyline rectangle clipper.
// -----------------------------------------------------------------------------
`default_nettype none
package prc_pkg;
	// configuration register indexes
	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOTTOM = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;
	localparam int CFG_IDX_W = 8;

	// request from sequencer to divider
	typedef struct packed {
		logic start;
	} div_ctl_t;
endpackage
`default_nettype wire

>>> design/prc_if.sv
// -----------------------------------------------------------------------------
// prc_if
// Ready/valid channel interfaces for the clipper.
// -----------------------------------------------------------------------------
`default_nettype none
interface prc_vtx_if #(parameter int CW = 24) ();
	logic          valid;
	logic          ready;
	logic [CW-1:0] vx;
	logic [CW-1:0] vy;
	logic          final_vertex;
	modport source (output valid, vx, vy, final_vertex, input ready);
	modport sink   (input valid, vx, vy, final_vertex, output ready);
endinterface

interface prc_pt_if #(parameter int CW = 24) ();
	logic          valid;
	logic          ready;
	logic [CW-1:0] px;
	logic [CW-1:0] py;
	logic          piece_start;
	logic          run_last;
	modport source (output valid, px, py, piece_start, run_last, input ready);
	modport sink   (input valid, px, py, piece_start, run_last, output ready);
endinterface

interface prc_cfg_if #(parameter int CW = 24) ();
	logic                          valid;
	logic                          ready;
	logic [prc_pkg::CFG_IDX_W-1:0] index;
	logic [CW-1:0]                 data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/prc_divider.sv
// -----------------------------------------------------------------------------
// prc_divider
// Restoring divider, one quotient bit per cycle, saturating t quotient.
// -----------------------------------------------------------------------------
`default_nettype none
module prc_divider
	import prc_pkg::*;
#(
	parameter int NW = 26,
	parameter int FB = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire div_ctl_t      ctl,
	input  wire logic [NW-1:0] num,
	input  wire logic [NW-1:0] den,
	output logic               done,
	output logic [FB+1:0]      quot
);
	localparam int QW = NW + FB;
	localparam int CNW = $clog2(QW + 1);
	localparam logic [QW-1:0] SAT = QW'((64'd1 << FB) + 64'd1);

	logic [QW-1:0]  dvd_q;
	logic [QW-1:0]  quo_q;
	logic [NW:0]    rem_q;
	logic [NW-1:0]  den_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic [NW:0]    trial;
	logic [NW:0]    diff;

	assign trial = {rem_q[NW-1:0], dvd_q[QW-1]};
	assign diff  = trial - {1'b0, den_q};

	// shift-subtract iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= {num, {FB{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			if (!diff[NW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign quot = (quo_q > SAT) ? (FB+2)'(SAT) : quo_q[FB+1:0];
endmodule
`default_nettype wire

>>> design/prc_seq.sv
// -----------------------------------------------------------------------------
// prc_seq
// Sequencer: edge tests on the shared divider, then interpolation.
// -----------------------------------------------------------------------------
`default_nettype none
module prc_seq
	import prc_pkg::*;
#(
	parameter int CW = 24,
	parameter int FB = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	prc_vtx_if.sink   vin,
	prc_pt_if.source  pout,
	prc_cfg_if.sink   cfg,
	output logic      busy
);
	localparam int NW = CW + 2;
	localparam int TW = FB + 2;
	localparam logic [TW-1:0] T_ONE = TW'(1) << FB;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EDGE = 4'd1;
	localparam logic [3:0] S_DIVW = 4'd2;
	localparam logic [3:0] S_DEC  = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_MACC = 4'd5;
	localparam logic [3:0] S_EMIT = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;

	logic [3:0] state_q;
	logic signed [CW-1:0] wl_q, wb_q, wr_q, wt_q;
	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
	logic have_prev_q, piece_open_q, fin_q;
	logic [1:0] edge_q;
	logic [TW-1:0] t0_q, t1_q;
	logic hit_q;
	// interpolation: ptsel_q 0..3 = t0.x t0.y t1.x t1.y
	logic [1:0] ptsel_q;
	logic signed [CW-1:0] res_q [4];
	logic signed [CW+1:0] pe_q, qe_q;
	logic emit0_q;
	logic out_v_q, out_phase_q;

	// current edge terms
	logic signed [CW+1:0] dx, dy, pe, qe;
	always_comb begin
		dx = (CW+2)'(bx_q) - (CW+2)'(ax_q);
		dy = (CW+2)'(by_q) - (CW+2)'(ay_q);
		case (edge_q)
			2'd0: begin pe = -dx; qe = (CW+2)'(ax_q) - (CW+2)'(wl_q); end
			2'd1: begin pe = dx;  qe = (CW+2)'(wr_q) - (CW+2)'(ax_q); end
			2'd2: begin pe = -dy; qe = (CW+2)'(ay_q) - (CW+2)'(wb_q); end
			default: begin pe = dy; qe = (CW+2)'(wt_q) - (CW+2)'(ay_q); end
		endcase
	end

	// divider operands use the registered edge terms
	logic signed [CW+1:0] num_s, den_s;
	assign num_s = pe_q[CW+1] ? -qe_q : qe_q;
	assign den_s = pe_q[CW+1] ? -pe_q : pe_q;
	div_ctl_t dctl;
	logic div_done;
	logic [TW-1:0] quot;
	logic div_go_q;
	assign dctl.start = div_go_q;

	prc_divider #(.NW(NW), .FB(FB)) u_div (
		.clk, .arst_n, .ctl(dctl), .num(num_s), .den(den_s),
		.done(div_done), .quot
	);

	// shared multiplier: |d| * t, registered; next product once the last is accumulated
	logic signed [CW:0] dsel;
	logic signed [CW-1:0] asel;
	logic [TW-1:0] tsel;
	logic [CW:0] dmag;
	always_comb begin
		asel = ptsel_q[0] ? ay_q : ax_q;
		dsel = ptsel_q[0] ? ((CW+1)'(by_q) - (CW+1)'(ay_q))
		                  : ((CW+1)'(bx_q) - (CW+1)'(ax_q));
		tsel = ptsel_q[1] ? t1_q : t0_q;
		dmag = dsel[CW] ? (CW+1)'(-dsel) : (CW+1)'(dsel);
	end
	logic [CW+TW:0] prod_q;
	logic neg_q;
	logic [CW+TW:0] rnd;
	assign rnd = prod_q + ((CW+TW+1)'(1) << (FB-1));

	assign busy = (state_q != S_IDLE);
	assign vin.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign pout.valid = out_v_q;
	assign pout.px = out_phase_q ? res_q[2] : res_q[0];
	assign pout.py = out_phase_q ? res_q[3] : res_q[1];
	assign pout.piece_start = !out_phase_q;
	assign pout.run_last = out_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wl_q <= '0; wb_q <= '0;
			wr_q <= CW'(262144); wt_q <= CW'(262144);
			have_prev_q <= 1'b0; piece_open_q <= 1'b0;
			ax_q <= '0; ay_q <= '0;
			div_go_q <= 1'b0;
			out_v_q <= 1'b0;
			out_phase_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (cfg.valid) begin
				case (cfg.index)
					CFG_IDX_W'(REG_LEFT):   wl_q <= cfg.data;
					CFG_IDX_W'(REG_BOTTOM): wb_q <= cfg.data;
					CFG_IDX_W'(REG_RIGHT):  wr_q <= cfg.data;
					CFG_IDX_W'(REG_TOP):    wt_q <= cfg.data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (vin.valid) begin
					bx_q <= vin.vx; by_q <= vin.vy; fin_q <= vin.final_vertex;
					edge_q <= 2'd0; t0_q <= '0; t1_q <= T_ONE; hit_q <= 1'b1;
					state_q <= have_prev_q ? S_EDGE : S_DEC;
				end
				// evaluate one edge
				S_EDGE: begin
					pe_q <= pe; qe_q <= qe;
					if (pe == '0) begin
						if (qe[CW+1]) hit_q <= 1'b0;
						edge_q <= edge_q + 1'b1;
						if (qe[CW+1] || edge_q == 2'd3) state_q <= S_DEC;
					end else if ((pe[CW+1] ? -qe : qe) < 0) begin
						// negative quotient: -1
						if (!pe[CW+1]) begin
							hit_q <= 1'b0; state_q <= S_DEC;
						end else begin
							edge_q <= edge_q + 1'b1;
							if (edge_q == 2'd3) state_q <= S_DEC;
						end
					end else begin
						div_go_q <= 1'b1; state_q <= S_DIVW;
					end
				end
				S_DIVW: if (div_done) begin
					logic [TW-1:0] n0, n1;
					n0 = t0_q; n1 = t1_q;
					if (pe_q[CW+1]) begin if (quot > n0) n0 = quot; end
					else begin if (quot < n1) n1 = quot; end
					t0_q <= n0; t1_q <= n1;
					edge_q <= edge_q + 1'b1;
					if (n0 > n1) begin hit_q <= 1'b0; state_q <= S_DEC; end
					else if (edge_q == 2'd3) state_q <= S_DEC;
					else state_q <= S_EDGE;
				end
				// decide on results, or finish item
				S_DEC: begin
					if (!have_prev_q) state_q <= S_OUT;
					else if (!hit_q) begin piece_open_q <= 1'b0; state_q <= S_OUT; end
					else begin
						emit0_q <= !piece_open_q || (t0_q != '0);
						piece_open_q <= (t1_q >= T_ONE);
						ptsel_q <= 2'd0; state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= (CW+TW+1)'(dmag) * (CW+TW+1)'(tsel);
					neg_q <= dsel[CW];
					state_q <= S_MACC;
				end
				S_MACC: begin
					if (neg_q) res_q[ptsel_q] <= asel - CW'(rnd >> FB);
					else       res_q[ptsel_q] <= asel + CW'(rnd >> FB);
					ptsel_q <= ptsel_q + 1'b1;
					state_q <= (ptsel_q == 2'd3) ? S_EMIT : S_MUL;
				end
				S_EMIT: begin
					if (!out_v_q) begin
						out_v_q <= 1'b1; out_phase_q <= !emit0_q;
					end else if (pout.ready) begin
						if (out_phase_q) begin out_v_q <= 1'b0; state_q <= S_OUT; end
						else out_phase_q <= 1'b1;
					end
				end
				S_OUT: begin
					ax_q <= bx_q; ay_q <= by_q;
					have_prev_q <= !fin_q;
					if (fin_q) piece_open_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/polyline_rect_clipper_unit.sv
// Channel   Dir  Payload
// vin       in   vx, vy, final_vertex
// pout      out  px, py, piece_start, run_last
// cfg       in   index, data (window edges)
// A segment is accepted, runs its edge tests (one per window edge) on the divider
// and is decided on; on a hit it is interpolated on the multiplier and gives
// up to two results. Then it is wrapped up. A first vertex is only accepted,
// decided on and wrapped up. Not ready while an item is in work. Results stall
// the block until taken. Reset is asynchronous, active low.
// -----------------------------------------------------------------------------
// polyline_rect_clipper_unit
// Streaming Liang-Barsky clipper of polylines against a window.
// -----------------------------------------------------------------------------
`default_nettype none
`include "polyline_rect_clipper_unit_defines.svh"
module polyline_rect_clipper_unit
	import prc_pkg::*;
#(
	parameter int COORD_WIDTH = 24,
	parameter int T_FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	prc_vtx_if.sink  vin,
	prc_pt_if.source pout,
	prc_cfg_if.sink  cfg
);
	logic busy;

	prc_seq #(.CW(COORD_WIDTH), .FB(T_FRAC_BITS)) u_seq (
		.clk, .arst_n, .vin, .pout, .cfg, .busy
	);

	`PRC_ASSERT_IMP(a_no_accept_busy, clk, arst_n, busy, !vin.ready)
	`PRC_ASSERT_IMP(a_out_only_busy, clk, arst_n, pout.valid, busy)
	`PRC_ASSERT_NXT(a_accept_busy, clk, arst_n, vin.valid && vin.ready, busy)
endmodule
`default_nettype wire

>>> test/prc_tb_if.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prc_tb_if
// Testbench note: the channel interfaces come from the design (prc_if.sv).
// This file holds the predictor types used by the checker.
// -----------------------------------------------------------------------------
package prc_tb_pkg;
	// one clipped point as the block should emit it
	typedef struct packed {
		logic [23:0] px;
		logic [23:0] py;
		logic        piece_start;
		logic        run_last;
	} clip_pt_t;
endpackage

>>> test/prc_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prc_checker
// Watches vertex, point and register channels, predicts clipped points and
// compares every point taken from the block against the oldest prediction.
// -----------------------------------------------------------------------------
module prc_checker
	import prc_pkg::*;
	import prc_tb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	prc_vtx_if vin,
	prc_pt_if  pout,
	prc_cfg_if cfg,
	output int errors,
	output int pending,
	output int points_seen
);
	localparam longint T_ONE = 64'sd1 << 16;

	longint win_l, win_b, win_r, win_t;
	longint last_x, last_y;
	bit     have_last, open_piece;
	clip_pt_t points_due[$];

	function automatic longint sx(logic [23:0] v);
		return longint'($signed(v));
	endfunction

	// edge quotient q/p in t units, saturated just above one
	function automatic longint edge_t(longint q, longint p);
		longint num, den, v;
		num = p < 0 ? -q : q;
		den = p < 0 ? -p : p;
		if (num < 0)
			return -1;
		v = (num <<< 16) / den;
		return v > T_ONE + 1 ? T_ONE + 1 : v;
	endfunction

	// a + round(d*t), half away from zero
	function automatic logic [23:0] lerp(longint a, longint b, longint t);
		longint d, r;
		d = b - a;
		r = (((d < 0 ? -d : d) * t) + (64'sd1 <<< 15)) >>> 16;
		return d < 0 ? 24'(a - r) : 24'(a + r);
	endfunction

	task automatic report(input string what);
		errors++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic clip_vertex(longint bx, longint by, bit fin);
		longint p[4], q[4], t0, t1, r;
		bit hit;
		clip_pt_t pt;
		if (have_last) begin
			t0 = 0;
			t1 = T_ONE;
			hit = 1;
			p[0] = -(bx - last_x); q[0] = last_x - win_l;
			p[1] = bx - last_x;    q[1] = win_r - last_x;
			p[2] = -(by - last_y); q[2] = last_y - win_b;
			p[3] = by - last_y;    q[3] = win_t - last_y;
			for (int i = 0; i < 4 && hit; i++) begin
				if (p[i] == 0) begin
					if (q[i] < 0) hit = 0;
					continue;
				end
				r = edge_t(q[i], p[i]);
				if (p[i] < 0) begin
					if (r > t0) t0 = r;
				end else if (r < t1) begin
					t1 = r;
				end
				if (t0 > t1) hit = 0;
			end
			if (!hit) begin
				open_piece = 0;
			end else begin
				if (!open_piece || t0 > 0) begin
					pt = {lerp(last_x, bx, t0), lerp(last_y, by, t0), 2'b10};
					points_due.insert(points_due.size(), pt);
				end
				pt = {lerp(last_x, bx, t1), lerp(last_y, by, t1), 2'b01};
				points_due.insert(points_due.size(), pt);
				open_piece = t1 >= T_ONE;
			end
		end
		last_x = bx;
		last_y = by;
		have_last = !fin;
		if (fin) open_piece = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		clip_pt_t want;
		if (!arst_n) begin
			win_l = 0; win_b = 0; win_r = 262144; win_t = 262144;
			last_x = 0; last_y = 0; have_last = 0; open_piece = 0;
			errors = 0;
			points_seen = 0;
			points_due.delete();
			pending = 0;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_IDX_W'(REG_LEFT):   win_l = sx(cfg.data);
					CFG_IDX_W'(REG_BOTTOM): win_b = sx(cfg.data);
					CFG_IDX_W'(REG_RIGHT):  win_r = sx(cfg.data);
					CFG_IDX_W'(REG_TOP):    win_t = sx(cfg.data);
					default: ;
				endcase
			end
			// compare taken points before the new vertex adds more
			if (pout.valid && pout.ready) begin
				points_seen++;
				if (points_due.size() == 0) begin
					report("point with none expected");
				end else begin
					want = points_due.pop_front();
					if (pout.px !== want.px)
						report($sformatf("px %h want %h", pout.px, want.px));
					if (pout.py !== want.py)
						report($sformatf("py %h want %h", pout.py, want.py));
					if (pout.piece_start !== want.piece_start)
						report("piece_start");
					if (pout.run_last !== want.run_last)
						report("run_last");
				end
			end
			if (vin.valid && vin.ready)
				clip_vertex(sx(vin.vx), sx(vin.vy), vin.final_vertex);
			pending = points_due.size();
		end
	end
endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Drives vertex streams and window settings into the clipper and gives the
// verdict from the checker's mismatch count.
// -----------------------------------------------------------------------------
module tb_top;
	import prc_pkg::*;

	localparam longint MAX_CYCLES = 2000000;

	logic clk = 0;
	logic arst_n = 0;
	int   errors, pending, points_seen;
	int   vtx_sent = 0;
	longint cycles = 0;
	bit   calm = 0;

	prc_vtx_if vin ();
	prc_pt_if  pout ();
	prc_cfg_if cfg ();

	polyline_rect_clipper_unit dut (.clk(clk), .arst_n(arst_n), .vin(vin), .pout(pout), .cfg(cfg));
	prc_checker chk (.clk(clk), .arst_n(arst_n), .vin(vin), .pout(pout), .cfg(cfg),
		.errors(errors), .pending(pending), .points_seen(points_seen));

	always #1 clk = ~clk;

	// timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("polyline_rect_clipper_unit regression: fail");
			$finish;
		end
	end

	// point sink with random stalls
	always @(negedge clk) begin
		pout.ready <= calm || $urandom_range(99) >= 38;
	end

	// valid stays up between writes; set_window drops it at the end
	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg.index <= CFG_IDX_W'(idx);
		cfg.data  <= val;
		cfg.valid <= 1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	task automatic set_window(logic [23:0] l, logic [23:0] b, logic [23:0] r, logic [23:0] t);
		write_reg(REG_LEFT, l);
		write_reg(REG_BOTTOM, b);
		write_reg(REG_RIGHT, r);
		write_reg(REG_TOP, t);
		cfg.valid <= 0;
	endtask

	// valid stays up after a request; it drops on idle cycles and in drain
	task automatic send_vertex(logic [23:0] x, logic [23:0] y, bit fin);
		while (!calm && $urandom_range(99) < 38) begin
			vin.valid <= 0;
			@(negedge clk);
		end
		vin.vx <= x;
		vin.vy <= y;
		vin.final_vertex <= fin;
		vin.valid <= 1;
		do @(posedge clk); while (!vin.ready);
		@(negedge clk);
		vtx_sent++;
	endtask

	// wait for every point, then let an idle segment finish
	task automatic drain();
		vin.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// coordinate mostly near the window, sometimes anywhere
	function automatic logic [23:0] coord();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 6) return 24'($signed($urandom_range(340000)) - 40000);
		if (sel < 8) return 24'($urandom);
		return sel == 8 ? 24'h7fffff : 24'h800000;
	endfunction

	task automatic random_lines(int n);
		int len;
		while (n > 0) begin
			len = $urandom_range(7, 1);
			for (int i = 0; i < len; i++)
				send_vertex(coord(), coord(), i == len - 1);
			n -= len;
		end
	endtask

	initial begin
		vin.valid = 0; vin.vx = 0; vin.vy = 0; vin.final_vertex = 0;
		cfg.valid = 0; cfg.index = 0; cfg.data = 0;
		pout.ready = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: reset window, crossings, misses, degenerate, single vertex
		send_vertex(24'd5000, 24'd5000, 1);
		send_vertex(-24'sd1000, 24'd1000, 0);
		send_vertex(24'd300000, 24'd1000, 0);
		send_vertex(24'd300000, 24'd300000, 0);
		send_vertex(24'd100000, 24'd100000, 0);
		send_vertex(24'd100000, 24'd100000, 0);
		send_vertex(24'd200000, 24'd200000, 0);
		send_vertex(24'd200000, -24'sd5, 0);
		send_vertex(24'h7fffff, 24'h800000, 0);
		send_vertex(24'h800000, 24'h7fffff, 1);
		send_vertex(24'd0, 24'd0, 0);
		send_vertex(24'd262144, 24'd262144, 1);
		drain();

		// extremes of the register range
		set_window(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
		send_vertex(24'h800000, 24'h800000, 0);
		send_vertex(24'h7fffff, 24'h7fffff, 0);
		send_vertex(24'h7fffff, 24'h800000, 1);
		drain();
		// inverted window
		set_window(24'd1000, 24'd1000, -24'sd1000, 24'd500);
		send_vertex(24'd0, 24'd0, 0);
		send_vertex(24'd2000, 24'd2000, 1);
		drain();

		// random parts under several windows, one stretch without idling
		set_window(24'd0, 24'd0, 24'd262144, 24'd262144);
		random_lines(200);
		drain();
		set_window(-24'sd20000, 24'd30000, 24'd150000, 24'd250000);
		calm = 1;
		random_lines(150);
		calm = 0;
		drain();
		set_window(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
		random_lines(50);
		drain();
		set_window(24'd0, -24'sd50000, 24'd200000, 24'd100000);
		random_lines(150);
		drain();

		$display("covered %0d vertices, %0d clipped points, 6 window settings",
			vtx_sent, points_seen);
		if (errors == 0)
			$display("polyline_rect_clipper_unit regression: pass");
		else
			$display("polyline_rect_clipper_unit regression: fail");
		$finish;
	end
endmodule
